### rtl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// shared types, codes and constants of the frame admission controller
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int SLOTS_DEF = 64;

  localparam int SID_W  = 32;
  localparam int REQ_W  = 64;
  localparam int FUNC_W = 3;
  localparam int ST_W   = 4;
  localparam int CAP_W  = 8;
  localparam int CNT_W  = 32;
  localparam int FL_W   = 4;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_REG      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_CLOSE    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_SUBMIT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_COMPLETE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PRESENT  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_ACCEPTED     = 4'd0;
  localparam logic [ST_W-1:0] ST_REPLACED     = 4'd1;
  localparam logic [ST_W-1:0] ST_SATURATED    = 4'd2;
  localparam logic [ST_W-1:0] ST_BACKPRESSURE = 4'd3;
  localparam logic [ST_W-1:0] ST_PRESENTED    = 4'd4;
  localparam logic [ST_W-1:0] ST_EMPTY        = 4'd5;
  localparam logic [ST_W-1:0] ST_CLOSED       = 4'd6;
  localparam logic [ST_W-1:0] ST_UNKNOWN      = 4'd7;
  localparam logic [ST_W-1:0] ST_INVALID      = 4'd8;

  // slot flag bit positions
  localparam int FL_REG    = 0;
  localparam int FL_CLOSED = 1;
  localparam int FL_PEND   = 2;
  localparam int FL_EDIT   = 3;

  // register indexes
  localparam logic REG_GEN_CAP = 1'b0;
  localparam logic REG_EDT_CAP = 1'b1;

  typedef struct packed {
    logic [SID_W-1:0] surface;
    logic [FL_W-1:0]  flags;
    logic [REQ_W-1:0] req;
  } slot_t;

endpackage

### rtl/fba_slot_ram.sv
// ----------------------------------------------------------------------------
// fba_slot_ram
// single write, single read slot table with registered read data
// ----------------------------------------------------------------------------
module fba_slot_ram #(
  parameter int SLOTS = fba_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  fba_pkg::slot_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output fba_pkg::slot_t           rd_data
);
  import fba_pkg::*;

  slot_t mem [SLOTS];
  slot_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/fba_mod_unit.sv
// ----------------------------------------------------------------------------
// fba_mod_unit
// remainder of the surface id by the slot count, one byte a cycle
// ----------------------------------------------------------------------------
module fba_mod_unit #(
  parameter int SLOTS = fba_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fba_pkg::SID_W-1:0]  dividend,
  output logic                       done,
  output logic [$clog2(SLOTS)-1:0]   rem
);
  import fba_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int NB = SID_W / 8;
  localparam int SW = $clog2(NB);
  localparam int TW = AW + 8;
  localparam int MW = TW + 2;
  localparam int SH = TW + AW;
  // rounded-up reciprocal, exact for every partial value below 2**TW
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);

  logic             run_r;
  logic             done_r;
  logic [SW-1:0]    step_r;
  logic [SID_W-1:0] sh_r;
  logic [AW-1:0]    rem_r;
  logic [TW-1:0]    part;
  logic [TW+MW-1:0] prod;
  logic [7:0]       quo;
  logic [TW-1:0]    quo_s;
  logic [AW-1:0]    rem_nxt;

  // fold in the next byte, then reduce by reciprocal multiply and subtract
  always_comb begin
    part    = {rem_r, sh_r[SID_W-1 -: 8]};
    prod    = {{MW{1'b0}}, part} * {{TW{1'b0}}, MW'(RECIP)};
    quo     = prod[SH +: 8];
    quo_s   = TW'(quo) * TW'(SLOTS);
    rem_nxt = AW'(part - quo_s);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == SW'(NB-1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      sh_r  <= {sh_r[SID_W-9:0], 8'd0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/frame_backpressure_admission_top.sv
// ----------------------------------------------------------------------------
// frame_backpressure_admission_top
// frame admission controller over a linearly probed surface slot table
// ----------------------------------------------------------------------------
// sequence: a bytewise remainder picks the home slot, slots are probed in turn,
//   all SLOTS for a full table; invalid codes and zero ids answer next cycle
// throughput: one request at a time, busy high until the result strobe;
//   the bytewise remainder and the one-probe-a-cycle table port set it
// reset: a clearing pass writes zeroes to every slot, busy held high;
//   results are never stalled by the receiver
module frame_backpressure_admission_top #(
  parameter int SLOTS = fba_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic [fba_pkg::FUNC_W-1:0]  in_func,
  input  logic [fba_pkg::SID_W-1:0]   in_surface_id,
  input  logic [fba_pkg::REQ_W-1:0]   in_request_id,
  input  logic                        in_editor_reserved,
  input  logic                        in_compositor_ready,
  // result channel
  output logic                        out_valid,
  output logic [fba_pkg::ST_W-1:0]    out_status,
  output logic [fba_pkg::REQ_W-1:0]   out_result_request,
  output logic [fba_pkg::CAP_W-1:0]   out_general_depth,
  output logic [fba_pkg::CAP_W-1:0]   out_editor_depth,
  output logic [fba_pkg::CNT_W-1:0]   out_saturation_events,
  output logic [fba_pkg::CNT_W-1:0]   out_backpressure_skips,
  output logic [fba_pkg::CNT_W-1:0]   out_presented_frames,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fba_pkg::*;

  localparam int AW = $clog2(SLOTS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_inc;

  logic [FUNC_W-1:0] func_r;
  logic [SID_W-1:0]  sid_r;
  logic [REQ_W-1:0]  req_r;
  logic              edit_r;
  logic              ready_r;

  logic [CAP_W-1:0]  gcap_r, ecap_r;
  logic [CAP_W-1:0]  gen_r, gen_nxt;
  logic [CAP_W-1:0]  edt_r, edt_nxt;
  logic [CNT_W-1:0]  satc_r, satc_nxt;
  logic [CNT_W-1:0]  skip_r, skip_nxt;
  logic [CNT_W-1:0]  pres_r, pres_nxt;

  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [REQ_W-1:0]  out_rr_r;

  logic              accept;
  logic              quick;
  logic [ST_W-1:0]   quick_st;
  logic              cfg_wr;

  logic              mod_start, mod_done;
  logic [AW-1:0]     mod_rem;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  slot_t             wr_data, ent;

  logic              hit;
  slot_t             ent_nxt;
  logic [ST_W-1:0]   dec_st;
  logic [REQ_W-1:0]  dec_rr;
  logic              do_rel;
  logic [CAP_W-1:0]  cap_eff;
  logic [CAP_W-1:0]  depth_sel;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_EDT_CAP) ? {24'd0, ecap_r} : {24'd0, gcap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcap_r <= CAP_W'(1);
      ecap_r <= CAP_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_EDT_CAP) begin
        ecap_r <= pwdata[CAP_W-1:0];
      end else begin
        gcap_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  // request decode: codes that need no table lookup
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    quick    = 1'b1;
    quick_st = ST_INVALID;
    if (in_func > FN_PRESENT) begin
      quick_st = ST_INVALID;
    end else if (in_func == FN_REG && in_surface_id == '0) begin
      quick_st = ST_INVALID;
    end else if (in_func == FN_SUBMIT && in_request_id == '0) begin
      quick_st = ST_INVALID;
    end else if (in_surface_id == '0) begin
      quick_st = ST_UNKNOWN;
    end else begin
      quick = 1'b0;
    end
  end

  assign mod_start = accept && !quick;

  fba_mod_unit #(.SLOTS(SLOTS)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_surface_id),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  fba_slot_ram #(.SLOTS(SLOTS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  assign idx_inc = (idx_r == AW'(SLOTS-1)) ? '0 : idx_r + 1'b1;
  assign hit     = (ent.surface == sid_r) || (ent.surface == '0);

  // slot update and outcome for a found slot
  always_comb begin
    ent_nxt         = ent;
    ent_nxt.surface = sid_r;
    dec_st          = ST_INVALID;
    dec_rr          = '0;
    do_rel          = 1'b0;
    gen_nxt         = gen_r;
    edt_nxt         = edt_r;
    satc_nxt        = satc_r;
    skip_nxt        = skip_r;
    pres_nxt        = pres_r;
    cap_eff         = ent.flags[FL_EDIT] ? ecap_r : gcap_r;
    if (cap_eff == '0) begin
      cap_eff = CAP_W'(1);
    end
    depth_sel = ent.flags[FL_EDIT] ? edt_r : gen_r;

    if (func_r == FN_REG) begin
      priority if (ent.flags[FL_CLOSED]) begin
        dec_st = ST_CLOSED;
      end else if (ent.flags[FL_REG]) begin
        if (edit_r) begin
          ent_nxt.flags[FL_EDIT] = 1'b1;
        end
        dec_st = ST_REPLACED;
      end else begin
        ent_nxt.flags          = '0;
        ent_nxt.flags[FL_REG]  = 1'b1;
        ent_nxt.flags[FL_EDIT] = edit_r;
        dec_st                 = ST_ACCEPTED;
      end
    end else if (!ent.flags[FL_REG]) begin
      dec_st = ST_UNKNOWN;
    end else if (ent.flags[FL_CLOSED]) begin
      dec_st = ST_CLOSED;
    end else begin
      unique case (func_r)
        FN_CLOSE: begin
          do_rel                   = ent.flags[FL_PEND];
          ent_nxt.flags[FL_PEND]   = 1'b0;
          ent_nxt.flags[FL_CLOSED] = 1'b1;
          dec_st                   = ST_ACCEPTED;
        end
        FN_SUBMIT: begin
          if (ent.flags[FL_PEND]) begin
            if (req_r <= ent.req) begin
              dec_st = ST_SATURATED;
              dec_rr = ent.req;
            end else begin
              ent_nxt.req = req_r;
              dec_st      = ST_REPLACED;
              dec_rr      = req_r;
            end
          end else if (depth_sel >= cap_eff) begin
            if (satc_r != CNT_MAX) begin
              satc_nxt = satc_r + 1'b1;
            end
            dec_st = ST_SATURATED;
          end else begin
            if (ent.flags[FL_EDIT]) begin
              edt_nxt = edt_r + 1'b1;
            end else begin
              gen_nxt = gen_r + 1'b1;
            end
            ent_nxt.req            = req_r;
            ent_nxt.flags[FL_PEND] = 1'b1;
            dec_st                 = ST_ACCEPTED;
            dec_rr                 = req_r;
          end
        end
        FN_COMPLETE: begin
          if (!ent.flags[FL_PEND] || ent.req != req_r) begin
            dec_st = ST_EMPTY;
          end else begin
            do_rel                 = 1'b1;
            ent_nxt.flags[FL_PEND] = 1'b0;
            dec_st                 = ST_ACCEPTED;
            dec_rr                 = req_r;
          end
        end
        FN_PRESENT: begin
          if (!ent.flags[FL_PEND]) begin
            dec_st = ST_EMPTY;
          end else if (!ready_r) begin
            if (skip_r != CNT_MAX) begin
              skip_nxt = skip_r + 1'b1;
            end
            dec_st = ST_BACKPRESSURE;
            dec_rr = ent.req;
          end else begin
            do_rel                 = 1'b1;
            ent_nxt.flags[FL_PEND] = 1'b0;
            if (pres_r != CNT_MAX) begin
              pres_nxt = pres_r + 1'b1;
            end
            dec_st = ST_PRESENTED;
            dec_rr = ent.req;
          end
        end
        default: begin
          dec_st = ST_INVALID;
        end
      endcase
    end

    // release a pending frame from its current lane
    if (do_rel) begin
      if (ent.flags[FL_EDIT]) begin
        if (edt_r != '0) begin
          edt_nxt = edt_r - 1'b1;
        end
      end else if (gen_r != '0) begin
        gen_nxt = gen_r - 1'b1;
      end
    end
  end

  // sequencer and table port control
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == AW'(SLOTS-1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && !quick) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          cnt_nxt   = '0;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        rd_en     = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (hit) begin
          state_nxt = S_DECIDE;
        end else if (cnt_r == AW'(SLOTS-1)) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc;
          idx_nxt = idx_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DECIDE: begin
        wr_en     = 1'b1;
        wr_data   = ent_nxt;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      gen_r       <= '0;
      edt_r       <= '0;
      satc_r      <= '0;
      skip_r      <= '0;
      pres_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b0;
      if (accept && quick) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_PROBE && !hit && cnt_r == AW'(SLOTS-1)) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == S_DECIDE) begin
        out_valid_r <= 1'b1;
        gen_r       <= gen_nxt;
        edt_r       <= edt_nxt;
        satc_r      <= satc_nxt;
        skip_r      <= skip_nxt;
        pres_r      <= pres_nxt;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r       <= in_func;
      sid_r        <= in_surface_id;
      req_r        <= in_request_id;
      edit_r       <= in_editor_reserved;
      ready_r      <= in_compositor_ready;
      out_status_r <= quick_st;
      out_rr_r     <= '0;
    end
    if (state_r == S_PROBE && !hit && cnt_r == AW'(SLOTS-1)) begin
      out_status_r <= (func_r == FN_REG) ? ST_SATURATED : ST_UNKNOWN;
      out_rr_r     <= '0;
    end
    if (state_r == S_DECIDE) begin
      out_status_r <= dec_st;
      out_rr_r     <= dec_rr;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_result_request     = out_rr_r;
  assign out_general_depth      = gen_r;
  assign out_editor_depth       = edt_r;
  assign out_saturation_events  = satc_r;
  assign out_backpressure_skips = skip_r;
  assign out_presented_frames   = pres_r;

  // checks
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !quick) |=> busy)
    else $error("table request accepted without going busy");

  a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_MOD))
    else $error("remainder finished outside its wait state");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR || state_r == S_DECIDE))
    else $error("table written outside clear or write back");

endmodule
